// ===== design/ppmsfd_pkg.sv =====
// Package for the PPM-sum frame decoder: register codes, reset values, filter codes,
// and the command and configuration types passed between the front, queue and back.
// No dependencies.
package ppmsfd_pkg;

    localparam int DATA_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int MINCH_W     = 4;
    localparam int MODE_W      = 2;
    localparam int CMD_IDX_W   = 4;
    localparam int CH_OUT_W    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SYNC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER    = 3'd5;

    localparam logic [DATA_W-1:0]  RST_MIN_PULSE = 16'd1800;
    localparam logic [DATA_W-1:0]  RST_MAX_PULSE = 16'd4200;
    localparam logic [DATA_W-1:0]  RST_MIN_SYNC  = 16'd5000;
    localparam logic [MINCH_W-1:0] RST_MIN_CHANS = 4'd4;
    localparam logic [MODE_W-1:0]  RST_FILTER    = 2'd0;
    localparam logic [DATA_W-1:0]  RST_JITTER    = 16'd4;

    // filter modes; the spare code behaves as FILT_NONE
    localparam logic [MODE_W-1:0] FILT_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] FILT_AVG    = 2'd1;
    localparam logic [MODE_W-1:0] FILT_JITTER = 2'd2;

    typedef enum logic [1:0] {
        OP_STORE,
        OP_PUBLISH,
        OP_FAIL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [CMD_IDX_W-1:0]  index;
        logic [DATA_W-1:0]     width;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  min_pulse;
        logic [DATA_W-1:0]  max_pulse;
        logic [DATA_W-1:0]  min_sync;
        logic [MINCH_W-1:0] min_channels;
        logic [MODE_W-1:0]  filter_mode;
        logic [DATA_W-1:0]  jitter;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/ppmsfd_front.sv =====
// Front end of the PPM-sum decoder: edge detection, width measurement, sync tracking
// and classification into store / publish / fail commands. Uses ppmsfd_pkg.
module ppmsfd_front #(
    parameter int N_CHANNELS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ppmsfd_pkg::cfg_t          cfg,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [15:0]               s_capture_time,
    input  logic                      s_line_level,
    input  ppmsfd_pkg::q_status_t     q_status,
    output logic                      push,
    output ppmsfd_pkg::cmd_t          push_cmd
);

    localparam int CNT_W = $clog2(N_CHANNELS + 2);
    localparam int CMP_W = (CNT_W > ppmsfd_pkg::MINCH_W) ? CNT_W : ppmsfd_pkg::MINCH_W;

    logic                          prev_level_reg, prev_level_next;
    logic [ppmsfd_pkg::DATA_W-1:0] last_edge_reg, last_edge_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          synced_reg, synced_next;

    logic                          accept;
    logic                          rise;
    logic [ppmsfd_pkg::DATA_W-1:0] width;
    logic                          good;
    logic                          is_sync;
    logic                          enough;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign rise    = s_line_level && !prev_level_reg;
    assign width   = s_capture_time - last_edge_reg;
    assign good    = (width < cfg.max_pulse) && (width > cfg.min_pulse) && synced_reg;
    assign is_sync = width > cfg.min_sync;
    assign enough  = CMP_W'(count_reg) >= CMP_W'(cfg.min_channels);

    always_comb begin
        prev_level_next = prev_level_reg;
        last_edge_next  = last_edge_reg;
        count_next      = count_reg;
        synced_next     = synced_reg;
        push            = 1'b0;
        push_cmd.op     = ppmsfd_pkg::OP_FAIL;
        push_cmd.index  = '0;
        push_cmd.width  = width;
        if (accept) begin
            prev_level_next = s_line_level;
            if (rise) begin
                last_edge_next = s_capture_time;
                priority if (good) begin
                    if (count_reg < CNT_W'(N_CHANNELS)) begin
                        push           = 1'b1;
                        push_cmd.op    = ppmsfd_pkg::OP_STORE;
                        push_cmd.index = ppmsfd_pkg::CMD_IDX_W'(count_reg);
                    end
                    count_next = count_reg + 1'b1;
                    // one channel too many: drop sync
                    if (count_reg == CNT_W'(N_CHANNELS)) begin
                        synced_next = 1'b0;
                    end
                end else if (is_sync && !synced_reg) begin
                    synced_next = 1'b1;
                    count_next  = '0;
                end else if (is_sync) begin
                    push        = 1'b1;
                    push_cmd.op = enough ? ppmsfd_pkg::OP_PUBLISH : ppmsfd_pkg::OP_FAIL;
                    count_next  = '0;
                end else begin
                    push        = 1'b1;
                    push_cmd.op = ppmsfd_pkg::OP_FAIL;
                    count_next  = '0;
                    synced_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b0;
            last_edge_reg  <= '0;
            count_reg      <= '0;
            synced_reg     <= 1'b0;
        end else begin
            prev_level_reg <= prev_level_next;
            last_edge_reg  <= last_edge_next;
            count_reg      <= count_next;
            synced_reg     <= synced_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(N_CHANNELS + 1))
        else $error("channel count beyond limit");

    a_overflow_unsynced: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > CNT_W'(N_CHANNELS)) |-> !synced_reg)
        else $error("still synced after channel overflow");

endmodule

// ===== design/ppmsfd_queue.sv =====
// Short command queue between the decoder front and back ends.
// Uses ppmsfd_pkg for the command type and depth.
module ppmsfd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ppmsfd_pkg::cmd_t      push_cmd,
    input  logic                  pop,
    output ppmsfd_pkg::cmd_t      head,
    output ppmsfd_pkg::q_status_t status
);

    ppmsfd_pkg::cmd_t                q_mem [ppmsfd_pkg::QUEUE_DEPTH];
    logic [ppmsfd_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ppmsfd_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ppmsfd_pkg::QCNT_W-1:0]   fill_reg;

    assign head         = q_mem[rd_ptr_reg];
    assign status.full  = fill_reg == ppmsfd_pkg::QCNT_W'(ppmsfd_pkg::QUEUE_DEPTH);
    assign status.empty = fill_reg == '0;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

// ===== design/ppmsfd_back.sv =====
// Back end of the PPM-sum decoder: working width store, filters (with a reciprocal
// multiply for the weighted average) and the result output register. Uses ppmsfd_pkg.
module ppmsfd_back #(
    parameter int N_CHANNELS     = 8,
    parameter int AVERAGE_WEIGHT = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ppmsfd_pkg::cfg_t          cfg,
    input  ppmsfd_pkg::cmd_t          head,
    input  ppmsfd_pkg::q_status_t     q_status,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_frame_good,
    output logic [2:0]                m_channel_index,
    output logic [15:0]               m_chan_width,
    output logic                      m_last_in_frame
);

    localparam int IDX_W    = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1;
    localparam int N_EMIT   = (N_CHANNELS > 8) ? 8 : N_CHANNELS;
    localparam int EMIT_W   = (N_EMIT > 1) ? $clog2(N_EMIT) : 1;
    localparam int DIVISOR  = AVERAGE_WEIGHT + 1;
    localparam int ACC_W    = ppmsfd_pkg::DATA_W + $clog2(DIVISOR);
    // floor(acc / DIVISOR) equals (acc * RECIP) >> RECIP_SH for every acc below 2**ACC_W
    localparam int RECIP_SH = ACC_W + $clog2(DIVISOR);
    localparam int RECIP    = ((1 << RECIP_SH) + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W   = ACC_W + RECIP_SH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [EMIT_W-1:0]             k_reg, k_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [IDX_W-1:0]              div_idx_reg, div_idx_next;
    logic                          m_valid_reg;
    logic                          m_good_reg;
    logic [ppmsfd_pkg::CH_OUT_W-1:0] m_idx_reg;
    logic [ppmsfd_pkg::DATA_W-1:0] m_width_reg;
    logic                          m_last_reg;

    logic [ppmsfd_pkg::DATA_W-1:0] store [N_CHANNELS];
    logic [IDX_W-1:0]              rd_addr;
    logic [ppmsfd_pkg::DATA_W-1:0] rd_data;
    logic                          we;
    logic [IDX_W-1:0]              waddr;
    logic [ppmsfd_pkg::DATA_W-1:0] wdata;

    logic                          out_free;
    logic                          out_load;
    logic                          out_good;
    logic [ppmsfd_pkg::CH_OUT_W-1:0] out_idx;
    logic [ppmsfd_pkg::DATA_W-1:0] out_width;
    logic                          out_last;

    logic [ppmsfd_pkg::DATA_W-1:0] diff;
    logic [ppmsfd_pkg::DATA_W-1:0] gated;
    logic [PROD_W-1:0]             avg_prod;
    logic                          emit_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign rd_addr   = (state_reg == S_EMIT) ? IDX_W'(k_reg) : head.index[IDX_W-1:0];
    assign rd_data   = store[rd_addr];
    assign diff      = (rd_data > head.width) ? (rd_data - head.width)
                                               : (head.width - rd_data);
    assign gated     = (diff > cfg.jitter) ? head.width : rd_data;
    assign avg_prod  = PROD_W'(acc_reg) * PROD_W'(RECIP);
    assign emit_last = k_reg == EMIT_W'(N_EMIT - 1);

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        div_idx_next = div_idx_reg;
        pop          = 1'b0;
        we           = 1'b0;
        waddr        = head.index[IDX_W-1:0];
        wdata        = head.width;
        out_load     = 1'b0;
        out_good     = 1'b0;
        out_idx      = '0;
        out_width    = '0;
        out_last     = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_status.empty) begin
                    unique case (head.op)
                        ppmsfd_pkg::OP_STORE: begin
                            pop = 1'b1;
                            unique case (cfg.filter_mode)
                                ppmsfd_pkg::FILT_AVG: begin
                                    acc_next = ACC_W'(AVERAGE_WEIGHT) * ACC_W'(rd_data)
                                             + ACC_W'(head.width);
                                    div_idx_next = head.index[IDX_W-1:0];
                                    state_next   = S_DIV;
                                end
                                ppmsfd_pkg::FILT_JITTER: begin
                                    we    = 1'b1;
                                    wdata = gated;
                                end
                                default: begin
                                    we = 1'b1;
                                end
                            endcase
                        end
                        ppmsfd_pkg::OP_PUBLISH: begin
                            pop        = 1'b1;
                            k_next     = '0;
                            state_next = S_EMIT;
                        end
                        default: begin
                            // failure item: hold until the output register is free
                            if (out_free) begin
                                pop      = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                // truncated average from the registered sum
                we         = 1'b1;
                waddr      = div_idx_reg;
                wdata      = avg_prod[RECIP_SH +: ppmsfd_pkg::DATA_W];
                state_next = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_good  = 1'b1;
                    out_idx   = ppmsfd_pkg::CH_OUT_W'(k_reg);
                    out_width = rd_data;
                    out_last  = emit_last;
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        acc_reg     <= acc_next;
        div_idx_reg <= div_idx_next;
        if (out_load) begin
            m_good_reg  <= out_good;
            m_idx_reg   <= out_idx;
            m_width_reg <= out_width;
            m_last_reg  <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_CHANNELS; i++) begin
                store[i] <= '0;
            end
        end else if (we) begin
            store[waddr] <= wdata;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_good    = m_good_reg;
    assign m_channel_index = m_idx_reg;
    assign m_chan_width    = m_width_reg;
    assign m_last_in_frame = m_last_reg;

    a_fail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_good_reg) |-> m_last_reg)
        else $error("failure item not marked last");

    a_div_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |=> (state_reg == S_IDLE))
        else $error("average write took more than one cycle");

endmodule

// ===== design/ppm_sum_frame_decoder_unit.sv =====
// Top level of the PPM-sum frame decoder: configuration registers and the
// front / queue / back chain. Uses ppmsfd_pkg, ppmsfd_front, ppmsfd_queue, ppmsfd_back.
//
//  channel   handshake              payload
//  s_        s_valid / s_ready      s_capture_time[15:0], s_line_level
//  m_        m_valid / m_ready      m_frame_good, m_channel_index[2:0],
//                                   m_chan_width[15:0], m_last_in_frame
//  cfg_      cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[15:0]
//
//  The front takes one pin-change item per cycle while the four-entry command queue has room.
//  The back writes a stored width directly in filter modes none and jitter gate; in
//  weighted-average mode it first registers the sum, then does the reciprocal multiply and write.
//  A publish moves the back to its emit state, which sends min(N_CHANNELS, 8) results, one
//  per cycle while the output register is free; a failure sends one.
//  Reset is synchronous, active low, and clears the working store.
//  A stalled result output holds the back; the front keeps taking items until the queue fills.
module ppm_sum_frame_decoder_unit #(
    parameter int N_CHANNELS     = 8,
    parameter int AVERAGE_WEIGHT = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_capture_time,
    input  logic        s_line_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_good,
    output logic [2:0]  m_channel_index,
    output logic [15:0] m_chan_width,
    output logic        m_last_in_frame,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ppmsfd_pkg::cfg_t      cfg_reg;
    ppmsfd_pkg::q_status_t q_status;
    ppmsfd_pkg::cmd_t      push_cmd;
    ppmsfd_pkg::cmd_t      head;
    logic                  push;
    logic                  pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulse    <= ppmsfd_pkg::RST_MIN_PULSE;
            cfg_reg.max_pulse    <= ppmsfd_pkg::RST_MAX_PULSE;
            cfg_reg.min_sync     <= ppmsfd_pkg::RST_MIN_SYNC;
            cfg_reg.min_channels <= ppmsfd_pkg::RST_MIN_CHANS;
            cfg_reg.filter_mode  <= ppmsfd_pkg::RST_FILTER;
            cfg_reg.jitter       <= ppmsfd_pkg::RST_JITTER;
        end else if (cfg_valid && cfg_ready) begin
            // indexes past the list are dropped
            unique case (cfg_index)
                ppmsfd_pkg::REG_MIN_PULSE: cfg_reg.min_pulse <= cfg_data;
                ppmsfd_pkg::REG_MAX_PULSE: cfg_reg.max_pulse <= cfg_data;
                ppmsfd_pkg::REG_MIN_SYNC:  cfg_reg.min_sync  <= cfg_data;
                ppmsfd_pkg::REG_MIN_CHANS:
                    cfg_reg.min_channels <= cfg_data[ppmsfd_pkg::MINCH_W-1:0];
                ppmsfd_pkg::REG_FILTER:
                    cfg_reg.filter_mode <= cfg_data[ppmsfd_pkg::MODE_W-1:0];
                ppmsfd_pkg::REG_JITTER:    cfg_reg.jitter    <= cfg_data;
                default: ;
            endcase
        end
    end

    ppmsfd_front #(
        .N_CHANNELS(N_CHANNELS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_capture_time (s_capture_time),
        .s_line_level   (s_line_level),
        .q_status       (q_status),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    ppmsfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    ppmsfd_back #(
        .N_CHANNELS     (N_CHANNELS),
        .AVERAGE_WEIGHT (AVERAGE_WEIGHT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .head            (head),
        .q_status        (q_status),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_good    (m_frame_good),
        .m_channel_index (m_channel_index),
        .m_chan_width    (m_chan_width),
        .m_last_in_frame (m_last_in_frame)
    );

endmodule
